// ----- sv/sns_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sns_pkg
// Shared widths, operation codes, sequencer states and the structs that pass
// between the sequencer, the shared divider and the top level.
// ----------------------------------------------------------------------------
package sns_pkg;

    // data widths
    localparam int VALUE_W = 32;
    localparam int PRIME_W = 16;
    localparam int OP_W    = 3;
    // trial divisor stays below 2^17
    localparam int DIV_W   = 17;
    localparam int CNT_W   = $clog2(VALUE_W);

    // operation codes
    localparam logic [OP_W-1:0] OP_FACTOR    = 3'd0;
    localparam logic [OP_W-1:0] OP_DOWN      = 3'd1;
    localparam logic [OP_W-1:0] OP_DOWN_EVEN = 3'd2;
    localparam logic [OP_W-1:0] OP_UP        = 3'd3;
    localparam logic [OP_W-1:0] OP_UP_EVEN   = 3'd4;

    // reset value of the prime limit register
    localparam logic [PRIME_W-1:0] PRIME_RESET = 16'd7;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_WAIT,
        ST_NEXT,
        ST_DONE
    } t_state;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [DIV_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic [DIV_W-1:0]   rem;
    } t_div_rsp;

    // finished result from the sequencer
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] answer;
        logic               status;
    } t_res;

endpackage

// ----- sv/smooth_number_search_top.sv -----
`timescale 1ns / 1ps
// Latency: data dependent. Each trial division runs through the shared divider;
// an item's work grows with the divides of the trial-division loop and with the
// candidates scanned by a search. Items settled by decode alone (values of one
// or less, even values to factor, a limit below two) need no division.
// Throughput: one item at a time; ready is high only while the sequencer idles.
// Reset (synchronous, active low) clears control state and sets the limit to 7.
// ----------------------------------------------------------------------------
// smooth_number_search_top
// Smallest prime factor and searches for numbers whose prime factors stay at
// or below a configured limit, using one shared iterative divider.
// ----------------------------------------------------------------------------
module smooth_number_search_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sns_pkg::OP_W-1:0]      i_operation,
    input  logic [sns_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sns_pkg::VALUE_W-1:0]   o_answer,
    output logic                          o_status,
    input  logic                          i_cfg_we,
    input  logic [sns_pkg::PRIME_W-1:0]   i_cfg_data
);

    logic [sns_pkg::PRIME_W-1:0]  r_largest_prime;
    logic                         r_out_valid;
    logic [sns_pkg::VALUE_W-1:0]  r_answer;
    logic                         r_status;

    sns_pkg::t_div_req            div_req;
    sns_pkg::t_div_rsp            div_rsp;
    sns_pkg::t_res                res;
    logic                         res_take;

    // prime limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest_prime <= sns_pkg::PRIME_RESET;
        end else if (i_cfg_we) begin
            r_largest_prime <= i_cfg_data;
        end
    end

    sns_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .i_largest_prime (r_largest_prime),
        .o_div_req       (div_req),
        .i_div_rsp       (div_rsp),
        .o_res           (res),
        .i_res_take      (res_take)
    );

    sns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // output register
    assign res_take = res.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_answer <= res.answer;
            r_status <= res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_status    = r_status;

endmodule

// ----- sv/sns_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sns_div
// Shared restoring divider: one quotient bit per cycle. Quotient and
// remainder hold until the next start.
// ----------------------------------------------------------------------------
module sns_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sns_pkg::t_div_req i_req,
    output sns_pkg::t_div_rsp o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [sns_pkg::CNT_W-1:0]         r_cnt;
    logic [sns_pkg::VALUE_W-1:0]       r_quot;
    logic [sns_pkg::DIV_W-1:0]         r_rem;
    logic [sns_pkg::DIV_W-1:0]         r_div;

    logic [sns_pkg::DIV_W:0]           rem_sh;
    logic [sns_pkg::DIV_W:0]           diff;
    logic                              fit;
    logic [sns_pkg::VALUE_W-1:0]       n_quot;
    logic [sns_pkg::DIV_W-1:0]         n_rem;

    // one shift-subtract step
    always_comb begin
        rem_sh = {r_rem, r_quot[sns_pkg::VALUE_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        fit    = rem_sh >= {1'b0, r_div};
        n_rem  = fit ? diff[sns_pkg::DIV_W-1:0] : rem_sh[sns_pkg::DIV_W-1:0];
        n_quot = {r_quot[sns_pkg::VALUE_W-2:0], fit};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + sns_pkg::CNT_W'(1);
                if (r_cnt == sns_pkg::CNT_W'(sns_pkg::VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- sv/sns_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sns_ctrl
// Sequencer: trial division for the smallest factor, and a candidate scan
// (down or up) that tests each candidate for smoothness through the divider.
// ----------------------------------------------------------------------------
module sns_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sns_pkg::OP_W-1:0]      i_operation,
    input  logic [sns_pkg::VALUE_W-1:0]   i_value,
    input  logic [sns_pkg::PRIME_W-1:0]   i_largest_prime,
    output sns_pkg::t_div_req             o_div_req,
    input  sns_pkg::t_div_rsp             i_div_rsp,
    output sns_pkg::t_res                 o_res,
    input  logic                          i_res_take
);

    localparam logic [sns_pkg::VALUE_W-1:0] ONE_V  = sns_pkg::VALUE_W'(1);
    localparam logic [sns_pkg::VALUE_W-1:0] ALL_V  = '1;

    sns_pkg::t_state                r_state, n_state;
    logic                           r_factor, n_factor;
    logic                           r_up, n_up;
    logic                           r_dbl, n_dbl;
    logic [sns_pkg::VALUE_W-1:0]    r_n, n_n;
    logic [sns_pkg::VALUE_W-1:0]    r_m, n_m;
    logic [sns_pkg::DIV_W-1:0]      r_d, n_d;
    logic [sns_pkg::VALUE_W-1:0]    r_lim, n_lim;
    logic [sns_pkg::VALUE_W-1:0]    r_answer, n_answer;
    logic                           r_status, n_status;

    logic                           accept;
    logic                           early;
    logic [sns_pkg::VALUE_W-1:0]    early_ans;
    logic                           early_stat;
    logic                           v_le1;
    logic                           p_lt2;
    logic [sns_pkg::VALUE_W-1:0]    p_ext;
    logic [sns_pkg::VALUE_W-1:0]    lo_even;
    logic [sns_pkg::VALUE_W-1:0]    lo_even_c;
    logic                           d_gt_q;
    logic                           d_gt_p;
    logic                           rem_zero;
    logic                           m_small;
    logic                           smooth_stop;
    logic [sns_pkg::DIV_W-1:0]      d_next;
    logic [sns_pkg::VALUE_W-1:0]    found;
    logic                           over_lim;
    logic                           n_le1;

    // shared decode
    always_comb begin
        accept      = i_in_valid && (r_state == sns_pkg::ST_IDLE);
        v_le1       = i_value <= ONE_V;
        p_lt2       = i_largest_prime < sns_pkg::PRIME_W'(2);
        p_ext       = sns_pkg::VALUE_W'(i_largest_prime);
        lo_even     = (i_value >> 1) + sns_pkg::VALUE_W'(i_value[0]);
        lo_even_c   = (lo_even == '0) ? ONE_V : lo_even;
        d_gt_q      = sns_pkg::VALUE_W'(r_d) > i_div_rsp.quot;
        d_gt_p      = r_d > sns_pkg::DIV_W'(i_largest_prime);
        rem_zero    = i_div_rsp.rem == '0;
        m_small     = (r_m == ONE_V) || (r_m <= p_ext);
        smooth_stop = d_gt_p || d_gt_q;
        d_next      = (r_d == sns_pkg::DIV_W'(2)) ? sns_pkg::DIV_W'(3)
                                                   : r_d + sns_pkg::DIV_W'(2);
        found       = r_dbl ? {r_n[sns_pkg::VALUE_W-2:0], 1'b0} : r_n;
        over_lim    = r_up && (r_n > r_lim);
        n_le1       = r_n <= ONE_V;
    end

    // items settled without any division
    always_comb begin
        early      = 1'b1;
        early_ans  = '0;
        early_stat = 1'b0;
        case (i_operation)
            sns_pkg::OP_FACTOR: begin
                if (v_le1) begin
                    early_ans = ONE_V;
                end else if (!i_value[0]) begin
                    early_ans = sns_pkg::VALUE_W'(2);
                end else begin
                    early = 1'b0;
                end
            end
            sns_pkg::OP_DOWN: begin
                early_ans = ONE_V;
                early     = v_le1 || p_lt2;
            end
            sns_pkg::OP_DOWN_EVEN: begin
                early_ans = v_le1 ? ONE_V : sns_pkg::VALUE_W'(2);
                early     = v_le1 || p_lt2;
            end
            sns_pkg::OP_UP: begin
                early      = p_lt2;
                early_ans  = v_le1 ? i_value : '0;
                early_stat = !v_le1;
            end
            sns_pkg::OP_UP_EVEN: begin
                early      = p_lt2;
                early_ans  = (lo_even_c == ONE_V) ? sns_pkg::VALUE_W'(2) : '0;
                early_stat = lo_even_c != ONE_V;
            end
            default: begin
                early_ans = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sns_pkg::ST_IDLE: begin
                if (accept) begin
                    if (early) begin
                        n_state = sns_pkg::ST_DONE;
                    end else if (i_operation == sns_pkg::OP_FACTOR) begin
                        n_state = sns_pkg::ST_DIV;
                    end else begin
                        n_state = sns_pkg::ST_TEST;
                    end
                end
            end
            sns_pkg::ST_TEST: begin
                if (over_lim || n_le1) begin
                    n_state = sns_pkg::ST_DONE;
                end else begin
                    n_state = sns_pkg::ST_DIV;
                end
            end
            sns_pkg::ST_DIV: begin
                n_state = sns_pkg::ST_WAIT;
            end
            sns_pkg::ST_WAIT: begin
                if (i_div_rsp.done) begin
                    if (r_factor) begin
                        n_state = (d_gt_q || rem_zero) ? sns_pkg::ST_DONE : sns_pkg::ST_DIV;
                    end else if (smooth_stop) begin
                        n_state = m_small ? sns_pkg::ST_DONE : sns_pkg::ST_NEXT;
                    end else begin
                        n_state = sns_pkg::ST_DIV;
                    end
                end
            end
            sns_pkg::ST_NEXT: begin
                if (r_up && (r_n == r_lim)) begin
                    n_state = sns_pkg::ST_DONE;
                end else begin
                    n_state = sns_pkg::ST_TEST;
                end
            end
            sns_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = sns_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sns_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_factor = r_factor;
        n_up     = r_up;
        n_dbl    = r_dbl;
        n_n      = r_n;
        n_m      = r_m;
        n_d      = r_d;
        n_lim    = r_lim;
        n_answer = r_answer;
        n_status = r_status;
        case (r_state)
            sns_pkg::ST_IDLE: begin
                n_answer = early_ans;
                n_status = early_stat;
                n_factor = i_operation == sns_pkg::OP_FACTOR;
                n_up     = (i_operation == sns_pkg::OP_UP) ||
                           (i_operation == sns_pkg::OP_UP_EVEN);
                n_dbl    = (i_operation == sns_pkg::OP_DOWN_EVEN) ||
                           (i_operation == sns_pkg::OP_UP_EVEN);
                n_m      = i_value;
                n_d      = sns_pkg::DIV_W'(3);
                n_lim    = (i_operation == sns_pkg::OP_UP_EVEN) ? (ALL_V >> 1) : ALL_V;
                case (i_operation)
                    sns_pkg::OP_DOWN_EVEN: n_n = i_value >> 1;
                    sns_pkg::OP_UP_EVEN:   n_n = lo_even_c;
                    default:               n_n = i_value;
                endcase
            end
            sns_pkg::ST_TEST: begin
                n_m = r_n;
                n_d = sns_pkg::DIV_W'(2);
                if (over_lim) begin
                    n_answer = '0;
                    n_status = 1'b1;
                end else begin
                    n_answer = found;
                    n_status = 1'b0;
                end
            end
            sns_pkg::ST_WAIT: begin
                if (i_div_rsp.done) begin
                    if (r_factor) begin
                        n_status = 1'b0;
                        if (d_gt_q) begin
                            n_answer = r_m;
                        end else if (rem_zero) begin
                            n_answer = sns_pkg::VALUE_W'(r_d);
                        end else begin
                            n_d = r_d + sns_pkg::DIV_W'(2);
                        end
                    end else if (smooth_stop) begin
                        n_answer = found;
                        n_status = 1'b0;
                    end else if (rem_zero) begin
                        n_m = i_div_rsp.quot;
                    end else begin
                        n_d = d_next;
                    end
                end
            end
            sns_pkg::ST_NEXT: begin
                if (r_up) begin
                    if (r_n == r_lim) begin
                        n_answer = '0;
                        n_status = 1'b1;
                    end else begin
                        n_n = r_n + ONE_V;
                    end
                end else begin
                    n_n = r_n - ONE_V;
                end
            end
            default: begin
                n_n = r_n;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready         = r_state == sns_pkg::ST_IDLE;
        o_div_req.start    = r_state == sns_pkg::ST_DIV;
        o_div_req.dividend = r_m;
        o_div_req.divisor  = r_d;
        o_res.valid        = r_state == sns_pkg::ST_DONE;
        o_res.answer       = r_answer;
        o_res.status       = r_status;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sns_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_factor <= n_factor;
        r_up     <= n_up;
        r_dbl    <= n_dbl;
        r_n      <= n_n;
        r_m      <= n_m;
        r_d      <= n_d;
        r_lim    <= n_lim;
        r_answer <= n_answer;
        r_status <= n_status;
    end

endmodule

// ----- sv/sns_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sns_chk
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
module sns_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [sns_pkg::VALUE_W-1:0]   o_answer,
    input  logic                          o_status
);

    // a result that waits keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_answer) && $stable(o_status))
        else $error("result changed while stalled");

    // one item at a time: ready drops after an accepted item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accept");

    // overflow status comes with a zero answer
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_answer == '0)
        else $error("overflow with nonzero answer");

    // after reset the block is idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind smooth_number_search_top sns_chk u_sns_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_answer    (o_answer),
    .o_status    (o_status)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for smooth_number_search_top. A class-based checker
// predicts the smallest prime factor and the smooth-number searches for every
// accepted item and compares each result field by field, in order. Stimulus
// covers directed corner cases, then random items under several prime limits
// and three idle patterns, with one long receiver stall.
// ----------------------------------------------------------------------------
module tb;
    import sns_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 20_000_000;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 9;
    localparam int          REPORT_MAX      = 10;

    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_W) - 1;

    // operation codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] answer;
        logic               status;
    } t_outcome;

    // predicts outcomes per item and checks them against the results in order
    class SmoothSearchChecker;
        logic [PRIME_W-1:0] prime_limit;
        t_outcome           pending_outcomes[$];
        int                 errors;

        function new();
            prime_limit = PRIME_RESET;
            errors      = 0;
        endfunction

        // every prime factor at or below the limit
        function bit is_smooth(longint unsigned m);
            longint unsigned d;
            longint unsigned p;
            p = prime_limit;
            d = 2;
            if (m <= 1) return 1'b1;
            while (d <= p && d * d <= m) begin
                while (m % d == 0) m = m / d;
                d = (d == 2) ? 3 : d + 2;
            end
            return (m == 1) || (m <= p);
        endfunction

        function longint unsigned least_factor(longint unsigned v);
            longint unsigned d;
            if (v <= 1) return 1;
            if (v % 2 == 0) return 2;
            for (d = 3; d <= v / d; d += 2)
                if (v % d == 0) return d;
            return v;
        endfunction

        // largest smooth number in [1, hi], hi >= 1
        function longint unsigned smooth_at_or_below(longint unsigned hi);
            longint unsigned n;
            n = hi;
            // no prime allowed: only 1 qualifies
            if (prime_limit < 2) return 1;
            while (!is_smooth(n)) n--;
            return n;
        endfunction

        // least smooth number in [lo, top], zero return when there is none
        function bit smooth_at_or_above(longint unsigned lo, longint unsigned top,
                                        output longint unsigned hit);
            longint unsigned n;
            hit = 0;
            if (lo > top) return 1'b0;
            if (prime_limit < 2 && lo > 1) return 1'b0;
            n = lo;
            while (!is_smooth(n)) begin
                if (n == top) return 1'b0;
                n++;
            end
            hit = n;
            return 1'b1;
        endfunction

        function t_outcome predict_outcome(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
            t_outcome        res;
            longint unsigned v;
            longint unsigned lo;
            longint unsigned hit;
            res.op     = op;
            res.value  = value;
            res.answer = '0;
            res.status = 1'b0;
            v = value;
            case (op)
                OP_FACTOR: res.answer = VALUE_W'(least_factor(v));
                OP_DOWN: res.answer = VALUE_W'((v <= 1) ? 1 : smooth_at_or_below(v));
                OP_DOWN_EVEN: begin
                    res.answer = VALUE_W'((v <= 1) ? 1 : 2 * smooth_at_or_below(v / 2));
                end
                OP_UP: begin
                    if (smooth_at_or_above(v, VALUE_MAX, hit)) res.answer = VALUE_W'(hit);
                    else res.status = 1'b1;
                end
                OP_UP_EVEN: begin
                    lo = v / 2 + v % 2;
                    if (lo < 1) lo = 1;
                    if (smooth_at_or_above(lo, VALUE_MAX / 2, hit))
                        res.answer = VALUE_W'(2 * hit);
                    else
                        res.status = 1'b1;
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
            pending_outcomes.push_back(predict_outcome(op, value));
        endfunction

        function void check_result(logic [VALUE_W-1:0] answer, logic status);
            t_outcome want;
            if (pending_outcomes.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: answer %0h status %0b", answer, status);
                return;
            end
            want = pending_outcomes.pop_front();
            if (want.answer !== answer || want.status !== status) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch op %0d value %0h limit %0d: expected %0h/%0b got %0h/%0b",
                             want.op, want.value, prime_limit, want.answer, want.status,
                             answer, status);
            end
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [OP_W-1:0]    operation = '0;
    logic [VALUE_W-1:0] value     = '0;
    logic               out_ready = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [PRIME_W-1:0] cfg_data  = '0;
    wire                in_ready;
    wire                out_valid;
    wire  [VALUE_W-1:0] answer;
    wire                status;

    SmoothSearchChecker board;
    int                 send_idle_pct = 11;
    int                 recv_idle_pct = 84;
    bit                 hold_go       = 1'b0;
    bit                 hold_taken    = 1'b0;
    int                 hold_left     = 0;
    int unsigned        cycle_count   = 0;

    smooth_number_search_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_operation(operation),
        .i_value    (value),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_answer   (answer),
        .o_status   (status),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // clock
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // result check
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_result(answer, status);
    end

    // offer one item, hold it until accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        do begin
            @(posedge clk);
        end while (!in_ready);
        board.note_item(op, v);
    endtask

    // drop valid and wait for every outstanding result
    task automatic end_stream();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [PRIME_W-1:0] lim);
        cfg_we   <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.prime_limit = lim;
    endtask

    // random item shaped so that searches stay short for the current limit
    task automatic random_item(output logic [OP_W-1:0] op, output logic [VALUE_W-1:0] v);
        longint unsigned s;
        longint unsigned p;
        longint unsigned k;
        int              lim;
        lim = board.prime_limit;
        if ($urandom_range(19, 0) == 0) op = OP_W'($urandom_range(OP_SPARE7, OP_SPARE5));
        else op = OP_W'($urandom_range(OP_UP_EVEN, OP_FACTOR));

        if (op == OP_FACTOR) begin
            // small numbers, or a small factor times a wide multiplier
            if ($urandom_range(1, 0) == 0) begin
                v = VALUE_W'($urandom_range(2047, 0));
            end else begin
                p = $urandom_range(60, 2);
                k = $urandom_range(32'hFFFF_FFFF / p, 1);
                v = VALUE_W'(p * k);
            end
        end else if (op > OP_UP_EVEN || lim < 2) begin
            v = ($urandom_range(1, 0) == 0) ? VALUE_W'($urandom()) :
                                              VALUE_W'($urandom_range(63, 0));
        end else if (lim <= 31 && $urandom_range(2, 0) == 0) begin
            // wide smooth number built from allowed primes, start a few steps off
            s = 1;
            repeat ($urandom_range(40, 4)) begin
                case ($urandom_range(5, 0))
                    0: p = 2;
                    1: p = 3;
                    2: p = 5;
                    3: p = 7;
                    4: p = 11;
                    default: p = 13;
                endcase
                if (p <= lim && s * p <= VALUE_MAX / 2) s = s * p;
            end
            k = $urandom_range(15, 0);
            case (op)
                OP_DOWN: v = VALUE_W'(s + k);
                OP_UP: v = VALUE_W'((s > k) ? s - k : s);
                OP_DOWN_EVEN: v = VALUE_W'(2 * s + k % 2);
                default: v = VALUE_W'(2 * s - k % 2);
            endcase
        end else begin
            if (lim < 7) v = VALUE_W'($urandom_range(255, 0));
            else if (lim > 31) v = VALUE_W'($urandom_range(1023, 0));
            else v = VALUE_W'($urandom_range(4095, 0));
        end
    endtask

    // main sequence
    initial begin
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] v;
        logic [PRIME_W-1:0] lim;
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            // idle pattern per phase group
            if (phase == 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 11;
            end
            if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                1: lim = 16'd0;
                2: lim = 16'd2;
                3: lim = 16'hFFFF;
                4: lim = 16'd1;
                5: lim = 16'd13;
                6: lim = 16'd31;
                default: lim = PRIME_RESET;
            endcase
            if (phase > 0) write_limit(lim);
            // short items here, so the held-off receiver fills the block quickly
            if (phase == 1) hold_go = 1'b1;

            // corner cases under the reset limit
            if (phase == 0) begin
                send_item(OP_FACTOR, 32'd0);
                send_item(OP_FACTOR, 32'd1);
                send_item(OP_FACTOR, 32'hFFFF_FFFF);
                send_item(OP_FACTOR, 32'hFFFF_FFFE);
                send_item(OP_FACTOR, 32'd25);
                send_item(OP_FACTOR, 32'd49);
                send_item(OP_FACTOR, 32'd143);
                send_item(OP_FACTOR, 32'd2021);
                send_item(OP_DOWN, 32'd1);
                send_item(OP_DOWN, 32'd11);
                send_item(OP_DOWN, 32'h8000_0000);
                send_item(OP_DOWN_EVEN, 32'd0);
                send_item(OP_DOWN_EVEN, 32'd23);
                send_item(OP_DOWN_EVEN, 32'h8000_0001);
                send_item(OP_UP, 32'd0);
                send_item(OP_UP, 32'd11);
                send_item(OP_UP, 32'hFFFF_FFFF);
                send_item(OP_UP_EVEN, 32'd1);
                send_item(OP_UP_EVEN, 32'd11);
                send_item(OP_UP_EVEN, 32'hFFFF_FFFF);
                send_item(OP_UP_EVEN, 32'hFFFF_FFFE);
                send_item(OP_SPARE5, 32'hFFFF_FFFF);
                send_item(OP_SPARE6, 32'd123);
                send_item(OP_SPARE7, 32'd0);
            end

            // no prime allowed: doubling only, upward search cannot end
            if (phase == 1) begin
                send_item(OP_DOWN, 32'd1000);
                send_item(OP_DOWN_EVEN, 32'd1000);
                send_item(OP_DOWN_EVEN, 32'd1);
                send_item(OP_UP, 32'd1);
                send_item(OP_UP, 32'd2);
                send_item(OP_UP_EVEN, 32'd0);
                send_item(OP_UP_EVEN, 32'd5);
            end

            repeat (ITEMS_PER_PHASE) begin
                random_item(op, v);
                send_item(op, v);
            end
            end_stream();
        end

        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
